// ===== rtl/sope_pkg.sv =====
// ----------------------------------------------------------------------------
// sope_pkg
// shared types, constants and cordic angle table of the event plane unit
// ----------------------------------------------------------------------------
package sope_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int SUM_W        = 48;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [14:0] ETA_LIMIT_RST = 15'd4096;
	localparam logic signed [33:0] ROT_GAIN = 34'sh0_26DD3B6A;

	// atan(2^-i) as a fraction of a full turn, 2^32 per turn
	localparam logic [31:0] TURN_ATAN [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	typedef struct packed {
		logic signed [SUM_W-1:0] qx;
		logic signed [SUM_W-1:0] qy;
	} sums_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_ROT,
		F_ACC
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_NORM,
		B_VEC,
		B_DONE
	} back_state_t;

endpackage

// ===== rtl/sope_front.sv =====
// ----------------------------------------------------------------------------
// sope_front
// takes tracks, applies the cuts, rotation cordic for cos/sin of 2phi and
// the per-event q-vector sums; hands closed events to the queue
// ----------------------------------------------------------------------------
module sope_front import sope_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    present,
	input  logic signed [15:0]      pt,
	input  logic signed [15:0]      phi,
	input  logic signed [15:0]      eta,
	input  logic                    last,
	input  logic [14:0]             eta_limit,
	input  q_status_t               q_stat,
	output logic                    push,
	output sums_t                   push_data
);

	front_state_t state_q, state_d;

	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0]         step_q;
	logic               flip_q;
	logic               last_q;
	logic signed [15:0] pt_q;
	logic signed [SUM_W-1:0] qx_q, qy_q;

	logic               accept;
	logic signed [16:0] abs_eta;
	logic               take;
	logic [31:0]        ang_raw, ang;
	logic               flip;
	logic signed [33:0] xs, ys;
	logic signed [33:0] atan_v;
	logic signed [34:0] xr, yr;
	logic signed [19:0] xt, yt;
	logic signed [16:0] cc, ss, c_fin, s_fin;
	logic signed [32:0] px, py;
	logic signed [SUM_W-1:0] qx_nx, qy_nx;

	assign accept  = in_valid && in_ready;
	assign abs_eta = eta[15] ? -{eta[15], eta} : {eta[15], eta};
	assign take    = present && !pt[15] && (abs_eta <= $signed({2'b00, eta_limit}));

	assign ang_raw = {phi[14:0], 17'd0};
	assign flip    = (ang_raw > 32'h4000_0000) && (ang_raw < 32'hC000_0000);
	assign ang     = flip ? (ang_raw ^ 32'h8000_0000) : ang_raw;

	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign atan_v = $signed({2'b00, TURN_ATAN[step_q]});

	// round half up to q15 and clamp to plus or minus one
	assign xr = {x_q[33], x_q} + 35'sd16384;
	assign yr = {y_q[33], y_q} + 35'sd16384;
	assign xt = xr[34:15];
	assign yt = yr[34:15];
	always_comb begin
		cc = (xt > 20'sd32768) ? 17'sd32768 : (xt < -20'sd32768) ? -17'sd32768 : xt[16:0];
		ss = (yt > 20'sd32768) ? 17'sd32768 : (yt < -20'sd32768) ? -17'sd32768 : yt[16:0];
		c_fin = flip_q ? -cc : cc;
		s_fin = flip_q ? -ss : ss;
	end

	assign px    = $signed({{17{pt_q[15]}}, pt_q}) * $signed({{16{c_fin[16]}}, c_fin});
	assign py    = $signed({{17{pt_q[15]}}, pt_q}) * $signed({{16{s_fin[16]}}, s_fin});
	assign qx_nx = qx_q + {{(SUM_W-33){px[32]}}, px};
	assign qy_nx = qy_q + {{(SUM_W-33){py[32]}}, py};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept && take) state_d = F_ROT;
			end
			F_ROT: begin
				if (step_q == 5'(CORDIC_STEPS - 1)) state_d = F_ACC;
			end
			F_ACC: state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		push      = 1'b0;
		push_data = '{qx: qx_q, qy: qy_q};
		case (state_q)
			F_IDLE: begin
				in_ready = !q_stat.full;
				push     = accept && !take && last;
			end
			F_ACC: begin
				push      = last_q;
				push_data = '{qx: qx_nx, qy: qy_nx};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			qx_q    <= '0;
			qy_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				F_IDLE: begin
					step_q <= '0;
					if (accept && !take && last) begin
						qx_q <= '0;
						qy_q <= '0;
					end
				end
				F_ROT: step_q <= step_q + 5'd1;
				F_ACC: begin
					qx_q <= last_q ? '0 : qx_nx;
					qy_q <= last_q ? '0 : qy_nx;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			x_q    <= ROT_GAIN;
			y_q    <= '0;
			z_q    <= {{2{ang[31]}}, ang};
			flip_q <= flip;
			pt_q   <= pt;
			last_q <= last;
		end else if (state_q == F_ROT) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end
		end
	end

endmodule

// ===== rtl/sope_queue.sv =====
// ----------------------------------------------------------------------------
// sope_queue
// short fifo of closed event sums between front and back
// ----------------------------------------------------------------------------
module sope_queue import sope_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sums_t     push_data,
	input  logic      pop,
	output sums_t     pop_data,
	output q_status_t stat,
	output logic [1:0] count
);

	sums_t      mem_q [QUEUE_DEPTH];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign pop_data   = mem_q[rd_q];
	assign stat.full  = (cnt_q == 2'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == 2'd0);
	assign count      = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

// ===== rtl/sope_back.sv =====
// ----------------------------------------------------------------------------
// sope_back
// per-event atan2: normalise, vectoring cordic, halve and wrap, output stage
// ----------------------------------------------------------------------------
module sope_back import sope_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  q_status_t               q_stat,
	input  sums_t                   q_data,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [15:0]      plane_angle,
	output logic signed [SUM_W-1:0] q_x,
	output logic signed [SUM_W-1:0] q_y
);

	back_state_t state_q, state_d;

	logic signed [63:0] x_q, y_q;
	logic [63:0]        m_q;
	logic [31:0]        z_q;
	logic [4:0]         step_q;
	sums_t              ev_q;
	logic               ov_q;
	logic signed [15:0] plane_q;
	logic signed [SUM_W-1:0] qxo_q, qyo_q;

	logic               is_zero, neg;
	logic signed [63:0] xl, yl, ay;
	logic signed [63:0] xs, ys;
	logic               norm_done, load_out;
	logic signed [32:0] zr;
	logic signed [16:0] pl, pw;

	assign is_zero = (q_data.qx == '0) && (q_data.qy == '0);
	assign neg     = q_data.qx[SUM_W-1];
	assign xl      = neg ? -64'(q_data.qx) : 64'(q_data.qx);
	assign yl      = neg ? -64'(q_data.qy) : 64'(q_data.qy);
	assign ay      = yl[63] ? -yl : yl;

	assign xs        = x_q >>> step_q;
	assign ys        = y_q >>> step_q;
	assign norm_done = m_q[63:59] != 5'd0;

	// halve with rounding, then fold into a half turn
	assign zr = $signed({z_q[31], z_q}) + 33'sd65536;
	assign pl = {zr[32], zr[32:17]};
	always_comb begin
		pw = pl;
		if (pl > 17'sd16384)  pw = pl - 17'sd32768;
		if (pl < -17'sd16384) pw = pl + 17'sd32768;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_stat.empty) state_d = is_zero ? B_DONE : B_NORM;
			end
			B_NORM: begin
				if (norm_done) state_d = B_VEC;
			end
			B_VEC: begin
				if (step_q == 5'(CORDIC_STEPS - 1)) state_d = B_DONE;
			end
			B_DONE: begin
				if (!ov_q || out_ready) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE: pop = !q_stat.empty;
			B_DONE: load_out = !ov_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load_out)       ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (state_q == B_VEC) step_q <= step_q + 5'd1;
			else                  step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ev_q <= q_data;
				x_q  <= xl;
				y_q  <= yl;
				m_q  <= (xl > ay) ? xl : ay;
				z_q  <= (neg && !is_zero) ? 32'h8000_0000 : 32'd0;
			end
			B_NORM: begin
				if (!norm_done) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
					m_q <= m_q << 1;
				end
			end
			B_VEC: begin
				if (!y_q[63]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + TURN_ATAN[step_q];
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - TURN_ATAN[step_q];
				end
			end
			default: ;
		endcase
		if (load_out) begin
			plane_q <= pw[15:0];
			qxo_q   <= ev_q.qx;
			qyo_q   <= ev_q.qy;
		end
	end

	assign out_valid   = ov_q;
	assign plane_angle = plane_q;
	assign q_x         = qxo_q;
	assign q_y         = qyo_q;

endmodule

// ===== rtl/second_order_event_plane_unit.sv =====
// ----------------------------------------------------------------------------
// second_order_event_plane_unit
// second-order event plane and q-vector sums from a stream of tracks
// ----------------------------------------------------------------------------
// A track that passes the cuts occupies the input through accept, 30
// rotation cordic steps and one accumulate; skipped tracks and bare end
// markers are taken without leaving the idle state. Closed events wait in a
// two-entry queue for the back end, whose atan2 (load, normalising shifts,
// 30 vectoring steps and output) runs alongside the front end; the input is
// ready only while the front end is idle and that queue is not full. eta_limit may be
// written at any cycle and takes effect for items accepted afterwards.
module second_order_event_plane_unit import sope_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [14:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    present,
	input  logic signed [15:0]      pt,
	input  logic signed [15:0]      phi,
	input  logic signed [15:0]      eta,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [15:0]      plane_angle,
	output logic signed [SUM_W-1:0] q_x,
	output logic signed [SUM_W-1:0] q_y
);

	logic [14:0] eta_limit_q;
	q_status_t   q_stat;
	logic        push, pop;
	sums_t       push_data, pop_data;
	logic [1:0]  q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        eta_limit_q <= ETA_LIMIT_RST;
		else if (cfg_valid) eta_limit_q <= cfg_data;
	end

	sope_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .present, .pt, .phi, .eta, .last,
		.eta_limit (eta_limit_q),
		.q_stat, .push, .push_data
	);

	sope_queue u_queue (
		.clk, .arst_n, .push, .push_data, .pop,
		.pop_data, .stat (q_stat), .count (q_count)
	);

	sope_back u_back (
		.clk, .arst_n, .q_stat, .q_data (pop_data), .pop,
		.out_valid, .out_ready, .plane_angle, .q_x, .q_y
	);

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= 2'(QUEUE_DEPTH))
		else $error("event queue overfilled");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("push into full event queue");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (plane_angle >= -16'sd16384) && (plane_angle <= 16'sd16384))
		else $error("plane angle outside a quarter turn");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !q_stat.full)
		else $error("input ready with full queue");

endmodule
